/* rtl/isp_pkg.sv */
`default_nettype none
package isp_pkg;
    localparam int SLOTS_DEF = 64;
    localparam int ITEM_WIDTH_DEF = 32;

    localparam logic [2:0] MODE_ADD = 3'd0;
    localparam logic [2:0] MODE_DEL = 3'd1;
    localparam logic [2:0] MODE_GET = 3'd2;
    localparam logic [2:0] MODE_SET = 3'd3;
    localparam logic [2:0] MODE_FIRST = 3'd4;
    localparam logic [2:0] MODE_NEXT = 3'd5;
    // unassigned codes, no operation
    localparam logic [2:0] MODE_RSV_LO = 3'd6;
    localparam logic [2:0] MODE_RSV_HI = 3'd7;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_FREE = 2'd3;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  slot_index;
        logic [31:0] item_data;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  slot_out;
        logic        slot_valid;
        logic [31:0] item_out;
        logic [6:0]  used_count;
        logic        pool_full;
    } t_rsp;

    // datapath command: which memory port action to take this cycle
    typedef enum logic [3:0] {
        C_IDLE,
        C_INIT,
        C_LATCH,
        C_RD_IDX,
        C_RD_FH,
        C_ADD_WR,
        C_ADD_TAIL,
        C_DEL_PV,
        C_DEL_NX,
        C_DEL_FT,
        C_DEL_SELF,
        C_SET_WR,
        C_RESP
    } t_cmd;

    typedef struct packed {
        logic       init_done;
        logic [2:0] mode;
        logic       in_range;
        logic       is_free;
        logic       can_add;
    } t_stat;
endpackage
`default_nettype wire

/* rtl/isp_datapath.sv */
`default_nettype none
module isp_datapath import isp_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF,
    parameter int ITEM_WIDTH = ITEM_WIDTH_DEF
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  t_cmd i_cmd,
    input  t_req i_req,
    output t_stat o_stat,
    output t_rsp o_rsp
);
    localparam int AW = $clog2(SLOTS);
    localparam int LW = $clog2(SLOTS + 1);
    localparam logic [LW-1:0] NONE = LW'(SLOTS);

    logic [ITEM_WIDTH-1:0] r_item [SLOTS];
    logic [LW-1:0] r_next [SLOTS];
    logic [LW-1:0] r_prev [SLOTS];
    logic [SLOTS-1:0] r_free;

    logic [LW-1:0] r_fh, r_ft, r_uh, r_ut, r_cnt;
    logic [AW:0]   r_init;
    logic          r_init_done;
    t_req          r_req;
    logic [LW-1:0] r_nx, r_pv;
    logic [ITEM_WIDTH-1:0] r_rd;
    t_rsp          r_rsp;
    // remembers whether the last add really allocated
    logic          r_add_ok;

    logic [AW-1:0] idx_a;
    logic in_range;
    assign in_range = {24'd0, r_req.slot_index} < 32'(SLOTS);
    assign idx_a = r_req.slot_index[AW-1:0];

    function automatic logic ok(input logic [LW-1:0] v);
        return v < NONE;
    endfunction

    logic [LW-1:0] idx_l;
    assign idx_l = LW'(r_req.slot_index);

    assign o_stat.init_done = r_init_done;
    assign o_stat.mode = r_req.mode;
    assign o_stat.in_range = in_range;
    assign o_stat.is_free = r_free[idx_a];
    assign o_stat.can_add = (r_cnt < NONE) && ok(r_fh);
    assign o_rsp = r_rsp;

    // memory ports: a single clocked block for all arrays
    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            C_INIT: begin
                r_item[r_init[AW-1:0]] <= '0;
                r_next[r_init[AW-1:0]] <= (r_init[AW-1:0] == AW'(SLOTS - 1)) ? NONE
                    : LW'(r_init[AW-1:0]) + LW'(1);
                r_prev[r_init[AW-1:0]] <= NONE;
            end
            C_RD_IDX: begin
                r_nx <= r_next[idx_a];
                r_pv <= r_prev[idx_a];
                r_rd <= r_item[idx_a];
            end
            C_RD_FH: r_nx <= r_next[r_fh[AW-1:0]];
            C_ADD_WR: begin
                r_item[r_fh[AW-1:0]] <= r_req.item_data[ITEM_WIDTH-1:0];
                r_next[r_fh[AW-1:0]] <= NONE;
                r_prev[r_fh[AW-1:0]] <= ok(r_ut) ? r_ut : NONE;
            end
            C_ADD_TAIL: if (ok(r_ut)) r_next[r_ut[AW-1:0]] <= r_fh;
            C_DEL_PV: if (ok(r_pv)) r_next[r_pv[AW-1:0]] <= ok(r_nx) ? r_nx : NONE;
            C_DEL_NX: if (ok(r_nx)) r_prev[r_nx[AW-1:0]] <= ok(r_pv) ? r_pv : NONE;
            C_DEL_FT: if (ok(r_ft)) r_next[r_ft[AW-1:0]] <= idx_l;
            C_DEL_SELF: begin
                r_next[idx_a] <= NONE;
                r_prev[idx_a] <= NONE;
            end
            C_SET_WR: r_item[idx_a] <= r_req.item_data[ITEM_WIDTH-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fh <= '0;
            r_ft <= NONE - LW'(1);
            r_uh <= NONE;
            r_ut <= NONE;
            r_cnt <= '0;
            r_free <= '1;
            r_init <= '0;
            r_init_done <= 1'b0;
        end else begin
            unique case (i_cmd)
                C_INIT: begin
                    r_init <= r_init + (AW + 1)'(1);
                    if (r_init == (AW + 1)'(SLOTS - 1)) r_init_done <= 1'b1;
                end
                C_LATCH: r_req <= i_req;
                C_ADD_WR: begin
                    r_free[r_fh[AW-1:0]] <= 1'b0;
                    if (!ok(r_ut)) r_uh <= r_fh;
                end
                C_ADD_TAIL: begin
                    r_ut <= r_fh;
                    r_cnt <= r_cnt + LW'(1);
                    r_fh <= ok(r_nx) ? r_nx : NONE;
                    if (!ok(r_nx)) r_ft <= NONE;
                end
                C_DEL_PV: if (!ok(r_pv)) r_uh <= ok(r_nx) ? r_nx : NONE;
                C_DEL_NX: if (!ok(r_nx)) r_ut <= ok(r_pv) ? r_pv : NONE;
                C_DEL_FT: begin
                    if (!ok(r_ft)) r_fh <= idx_l;
                    r_ft <= idx_l;
                    r_free[idx_a] <= 1'b1;
                    if (r_cnt != '0) r_cnt <= r_cnt - LW'(1);
                end
                default: ;
            endcase
        end
    end

    // result assembly from the values left after the operation
    always_ff @(posedge i_clk) begin
        if (i_cmd == C_RESP) begin
            r_rsp.status <= ST_OK;
            r_rsp.slot_out <= '0;
            r_rsp.slot_valid <= 1'b0;
            r_rsp.item_out <= '0;
            r_rsp.used_count <= 7'(r_cnt);
            r_rsp.pool_full <= (r_cnt >= NONE);
            unique case (r_req.mode)
                MODE_ADD: begin
                    if (r_add_ok) begin
                        r_rsp.slot_out <= 6'(r_ut);
                        r_rsp.slot_valid <= 1'b1;
                    end else begin
                        r_rsp.status <= ST_FULL;
                    end
                end
                MODE_DEL, MODE_SET: if (!in_range) r_rsp.status <= ST_RANGE;
                MODE_GET: begin
                    if (!in_range) r_rsp.status <= ST_RANGE;
                    else if (r_free[idx_a]) r_rsp.status <= ST_FREE;
                    else r_rsp.item_out <= 32'(r_rd);
                end
                MODE_FIRST: if (ok(r_uh)) begin
                    r_rsp.slot_out <= 6'(r_uh);
                    r_rsp.slot_valid <= 1'b1;
                end
                MODE_NEXT: begin
                    if (!in_range) r_rsp.status <= ST_RANGE;
                    else if (ok(r_nx)) begin
                        r_rsp.slot_out <= 6'(r_nx);
                        r_rsp.slot_valid <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == C_LATCH) r_add_ok <= 1'b0;
        else if (i_cmd == C_ADD_WR) r_add_ok <= 1'b1;
    end
endmodule
`default_nettype wire

/* rtl/isp_ctrl.sv */
`default_nettype none
module isp_ctrl import isp_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    output logic  o_in_stall,
    output logic  o_out_valid,
    input  wire   i_out_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DEC, S_ADD_RD, S_ADD_WR, S_ADD_TAIL,
        S_DEL_PV, S_DEL_NX, S_DEL_FT, S_DEL_SELF, S_SET, S_RESP, S_FIX, S_OUT
    } t_state;
    t_state r_state, n_state;
    logic r_out_valid;

    assign o_out_valid = r_out_valid;
    assign o_in_stall = (r_state != S_IDLE) || r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd = C_IDLE;
        unique case (r_state)
            S_INIT: begin
                o_cmd = C_INIT;
                if (i_stat.init_done) begin
                    o_cmd = C_IDLE;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: if (i_in_valid && !r_out_valid) begin
                o_cmd = C_LATCH;
                n_state = S_DEC;
            end
            S_DEC: begin
                o_cmd = C_RD_IDX;
                unique case (i_stat.mode)
                    MODE_ADD: n_state = i_stat.can_add ? S_ADD_RD : S_FIX;
                    MODE_DEL: n_state = (i_stat.in_range && !i_stat.is_free)
                        ? S_DEL_PV : S_RESP;
                    MODE_SET: n_state = i_stat.in_range ? S_SET : S_RESP;
                    default: n_state = S_RESP;
                endcase
            end
            S_ADD_RD: begin o_cmd = C_RD_FH; n_state = S_ADD_WR; end
            S_ADD_WR: begin o_cmd = C_ADD_WR; n_state = S_ADD_TAIL; end
            S_ADD_TAIL: begin
                o_cmd = C_ADD_TAIL;
                n_state = S_RESP;
            end
            S_DEL_PV: begin o_cmd = C_DEL_PV; n_state = S_DEL_NX; end
            S_DEL_NX: begin o_cmd = C_DEL_NX; n_state = S_DEL_FT; end
            S_DEL_FT: begin o_cmd = C_DEL_FT; n_state = S_DEL_SELF; end
            S_DEL_SELF: begin o_cmd = C_DEL_SELF; n_state = S_RESP; end
            S_SET: begin o_cmd = C_SET_WR; n_state = S_RESP; end
            S_RESP: begin o_cmd = C_RESP; n_state = S_OUT; end
            S_FIX: begin o_cmd = C_RESP; n_state = S_OUT; end
            S_OUT: begin o_cmd = C_IDLE; n_state = S_IDLE; end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT) r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
        end
    end
endmodule
`default_nettype wire

/* rtl/indexed_slot_pool.sv */
`default_nettype none
// Slot pool with a FIFO free list and an allocation-ordered used list kept in
// link memories. One operation at a time: after a clearing pass that follows
// reset and visits every slot, get, first, next, an add on a full pool, a
// delete of a free slot and out-of-range requests go from decode straight to
// the result, while set, add and delete first pass through their memory
// states; the writes go one per state, of which delete needs four. The next
// request is taken once the result beat has left.
module indexed_slot_pool import isp_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF,
    parameter int ITEM_WIDTH = ITEM_WIDTH_DEF
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  wire  i_out_stall,
    output t_rsp o_out_data
);
    t_cmd  cmd;
    t_stat stat;

    isp_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall), .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall), .i_stat(stat), .o_cmd(cmd)
    );

    isp_datapath #(.SLOTS(SLOTS), .ITEM_WIDTH(ITEM_WIDTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_req(i_in_data),
        .o_stat(stat), .o_rsp(o_out_data)
    );

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall) else $error("accept while result pending");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result dropped");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.used_count <= 7'(SLOTS)))
        else $error("count overflow");
endmodule
`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    import isp_pkg::*;

    localparam int NSLOT = 64;
    localparam int NONE = NSLOT;
    localparam int WD_LIMIT = 4000;

    logic i_clk;
    logic i_rst_n;
    logic in_valid;
    logic in_stall;
    t_req in_data;
    logic out_valid;
    logic out_stall;
    t_rsp out_data;

    indexed_slot_pool u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_in_data(in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data(out_data)
    );

    // pool shadow state
    logic [31:0] shadow_item [NSLOT];
    int          shadow_next [NSLOT];
    int          shadow_prev [NSLOT];
    bit          shadow_free [NSLOT];
    int fl_head, fl_tail, used_head, used_tail, used_n;

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    int   err_count = 0;
    int   rsp_count = 0;
    int   req_count = 0;
    int   wd_count = 0;
    bit   hold_for_drain = 0;
    int   send_wait = 0;
    int   recv_wait = 0;
    int   mode_hits [8];

    function automatic bit link_ok(int v);
        return v >= 0 && v < NSLOT;
    endfunction

    function automatic void pool_reset();
        for (int i = 0; i < NSLOT; i++) begin
            shadow_item[i] = '0;
            shadow_next[i] = i + 1;
            shadow_prev[i] = NONE;
            shadow_free[i] = 1'b1;
        end
        shadow_next[NSLOT-1] = NONE;
        fl_head = 0;
        fl_tail = NSLOT - 1;
        used_head = NONE;
        used_tail = NONE;
        used_n = 0;
    endfunction

    function automatic t_rsp pool_apply(t_req r);
        t_rsp o;
        int idx;
        int s, nf, pv, nx;
        bit in_rng;
        idx = r.slot_index;
        in_rng = idx < NSLOT;
        o = '0;
        case (r.mode)
            MODE_ADD: begin
                if (used_n >= NSLOT || !link_ok(fl_head)) begin
                    o.status = ST_FULL;
                end else begin
                    s = fl_head;
                    nf = shadow_next[s];
                    fl_head = link_ok(nf) ? nf : NONE;
                    if (!link_ok(fl_head)) fl_tail = NONE;
                    shadow_item[s] = r.item_data;
                    shadow_free[s] = 1'b0;
                    shadow_next[s] = NONE;
                    if (!link_ok(used_tail)) begin
                        used_head = s;
                        shadow_prev[s] = NONE;
                    end else begin
                        shadow_next[used_tail] = s;
                        shadow_prev[s] = used_tail;
                    end
                    used_tail = s;
                    used_n++;
                    o.slot_out = s[5:0];
                    o.slot_valid = 1'b1;
                end
            end
            MODE_DEL: begin
                if (!in_rng) begin
                    o.status = ST_RANGE;
                end else if (!shadow_free[idx]) begin
                    shadow_free[idx] = 1'b1;
                    pv = shadow_prev[idx];
                    nx = shadow_next[idx];
                    if (link_ok(pv)) shadow_next[pv] = link_ok(nx) ? nx : NONE;
                    else used_head = link_ok(nx) ? nx : NONE;
                    if (link_ok(nx)) shadow_prev[nx] = link_ok(pv) ? pv : NONE;
                    else used_tail = link_ok(pv) ? pv : NONE;
                    if (link_ok(fl_tail)) shadow_next[fl_tail] = idx;
                    else fl_head = idx;
                    fl_tail = idx;
                    shadow_next[idx] = NONE;
                    shadow_prev[idx] = NONE;
                    if (used_n > 0) used_n--;
                end
            end
            MODE_GET: begin
                if (!in_rng) o.status = ST_RANGE;
                else if (shadow_free[idx]) o.status = ST_FREE;
                else o.item_out = shadow_item[idx];
            end
            MODE_SET: begin
                if (!in_rng) o.status = ST_RANGE;
                else shadow_item[idx] = r.item_data;
            end
            MODE_FIRST: begin
                if (link_ok(used_head)) begin
                    o.slot_out = used_head[5:0];
                    o.slot_valid = 1'b1;
                end
            end
            MODE_NEXT: begin
                if (!in_rng) begin
                    o.status = ST_RANGE;
                end else if (link_ok(shadow_next[idx])) begin
                    o.slot_out = shadow_next[idx][5:0];
                    o.slot_valid = 1'b1;
                end
            end
            default: ;
        endcase
        o.used_count = used_n[6:0];
        o.pool_full = used_n >= NSLOT;
        return o;
    endfunction

    function automatic void push_req(logic [2:0] m, logic [7:0] idx, logic [31:0] d);
        t_req r;
        r.mode = m;
        r.slot_index = idx;
        r.item_data = d;
        pending_reqs.push_back(r);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_data <= '0;
            send_wait <= 0;
        end else if (in_valid && !in_stall) begin
            in_valid <= 1'b0;
            send_wait <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
        end else if (!in_valid) begin
            if (send_wait > 0) begin
                send_wait <= send_wait - 1;
            end else if (pending_reqs.size() > 0 &&
                         !(hold_for_drain && expected_rsps.size() > 0)) begin
                in_data <= pending_reqs.pop_front();
                in_valid <= 1'b1;
            end
        end
    end

    // on accept, predict the result
    always @(posedge i_clk) begin
        if (i_rst_n && in_valid && !in_stall) begin
            expected_rsps.push_back(pool_apply(in_data));
            mode_hits[in_data.mode]++;
            req_count++;
        end
    end

    // monitor and output stall
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            recv_wait <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                rsp_count++;
                if (expected_rsps.size() == 0) begin
                    $display("%0t: unexpected beat %h", $time, out_data);
                    err_count++;
                end else begin
                    want = expected_rsps.pop_front();
                    if (want.status !== out_data.status)
                        $display("%0t: status exp %0d got %0d", $time,
                                 want.status, out_data.status);
                    if (want.slot_out !== out_data.slot_out)
                        $display("%0t: slot_out exp %0d got %0d", $time,
                                 want.slot_out, out_data.slot_out);
                    if (want.slot_valid !== out_data.slot_valid)
                        $display("%0t: slot_valid exp %0d got %0d", $time,
                                 want.slot_valid, out_data.slot_valid);
                    if (want.item_out !== out_data.item_out)
                        $display("%0t: item_out exp %h got %h", $time,
                                 want.item_out, out_data.item_out);
                    if (want.used_count !== out_data.used_count)
                        $display("%0t: used_count exp %0d got %0d", $time,
                                 want.used_count, out_data.used_count);
                    if (want.pool_full !== out_data.pool_full)
                        $display("%0t: pool_full exp %0d got %0d", $time,
                                 want.pool_full, out_data.pool_full);
                    if (want !== out_data) err_count++;
                end
            end
            if (recv_wait > 0) begin
                recv_wait <= recv_wait - 1;
                out_stall <= 1'b1;
            end else if (out_valid && !out_stall) begin
                if ($urandom_range(0, 2) == 0) begin
                    recv_wait <= $urandom_range(0, 14);
                    out_stall <= 1'b1;
                end else begin
                    out_stall <= 1'b0;
                end
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog: the clearing pass after reset falls well inside the limit
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            wd_count <= 0;
        end else begin
            wd_count <= wd_count + 1;
            if (wd_count >= WD_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        int m;
        int burst;
        pool_reset();
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty pool corners, ranges, unassigned modes
        push_req(MODE_FIRST, 8'd0, 32'd0);
        push_req(MODE_GET, 8'd0, 32'd0);
        push_req(MODE_NEXT, 8'd0, 32'd0);
        push_req(MODE_NEXT, 8'(NSLOT - 1), 32'd0);
        push_req(MODE_DEL, 8'd5, 32'd0);
        push_req(MODE_SET, 8'd3, 32'hFFFF_FFFF);
        push_req(MODE_DEL, 8'd255, 32'd0);
        push_req(MODE_GET, 8'(NSLOT), 32'd0);
        push_req(MODE_SET, 8'd200, 32'd1);
        push_req(MODE_NEXT, 8'd128, 32'd0);
        push_req(MODE_RSV_LO, 8'hFF, 32'hFFFF_FFFF);
        push_req(MODE_RSV_HI, 8'h00, 32'h0);
        push_req(MODE_ADD, 8'd0, 32'hFFFF_FFFF);
        push_req(MODE_ADD, 8'd0, 32'h0);
        push_req(MODE_ADD, 8'd0, 32'hA5A5_5A5A);
        push_req(MODE_GET, 8'd0, 32'd0);
        push_req(MODE_FIRST, 8'd0, 32'd0);
        push_req(MODE_NEXT, 8'd0, 32'd0);
        push_req(MODE_DEL, 8'd1, 32'd0);
        push_req(MODE_NEXT, 8'd0, 32'd0);
        push_req(MODE_DEL, 8'd0, 32'd0);
        push_req(MODE_FIRST, 8'd0, 32'd0);
        push_req(MODE_DEL, 8'd2, 32'd0);
        push_req(MODE_GET, 8'd3, 32'd0);
        // fill to full, overflow, then delete every slot in index order
        for (int i = 0; i < NSLOT + 2; i++) push_req(MODE_ADD, 8'd0, $urandom);
        push_req(MODE_FIRST, 8'd0, 32'd0);
        for (int i = 0; i < NSLOT; i++) push_req(MODE_DEL, 8'(i), 32'd0);

        // random phases with varying add/delete balance
        while (pending_reqs.size() + req_count < 1850) begin
            burst = $urandom_range(20, 80);
            m = $urandom_range(0, 2);
            for (int i = 0; i < burst; i++) begin
                int r;
                r = $urandom_range(0, 99);
                if (r < (m == 0 ? 50 : m == 1 ? 25 : 10))
                    push_req(MODE_ADD, 8'($urandom), $urandom);
                else if (r < 55)
                    push_req(MODE_DEL, 8'($urandom_range(0, NSLOT - 1)), $urandom);
                else if (r < 67)
                    push_req(MODE_GET, 8'($urandom_range(0, 255) < 230 ?
                             $urandom_range(0, NSLOT - 1) : $urandom_range(0, 255)),
                             $urandom);
                else if (r < 77)
                    push_req(MODE_SET, $urandom_range(0, 255) < 230 ?
                             8'($urandom_range(0, NSLOT - 1)) : 8'($urandom), $urandom);
                else if (r < 83)
                    push_req(MODE_FIRST, 8'($urandom), $urandom);
                else if (r < 97)
                    push_req(MODE_NEXT, $urandom_range(0, 255) < 230 ?
                             8'($urandom_range(0, NSLOT - 1)) : 8'($urandom), $urandom);
                else
                    push_req($urandom_range(0, 1) ? MODE_RSV_HI : MODE_RSV_LO,
                             8'($urandom), $urandom);
            end
        end

        // midway drain pause: nothing new goes out until every result is back
        wait (pending_reqs.size() < 900);
        @(posedge i_clk);
        hold_for_drain <= 1'b1;
        @(posedge i_clk);
        wait (!in_valid && expected_rsps.size() == 0);
        repeat (20) @(posedge i_clk);
        hold_for_drain <= 1'b0;

        wait (pending_reqs.size() == 0 && !in_valid);
        wait (expected_rsps.size() == 0);
        repeat (40) @(posedge i_clk);
        $display("covered %0d requests: add %0d del %0d get %0d set %0d first %0d next %0d",
                 req_count, mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3],
                 mode_hits[4], mode_hits[5]);
        $display("%0d results checked, %0d mismatches", rsp_count, err_count);
        if (err_count == 0 && expected_rsps.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
